// ===== rtl/ssd_pkg.sv =====
`timescale 1ns / 1ps

package ssd_pkg;

    typedef struct packed {
        logic signed [31:0] item_value;
        logic               item_last;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               sorted_last;
        logic               dropped;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic               clear;
        logic               sample_en;
        logic signed [31:0] sample_value;
    } max_ctrl_t;

    typedef struct packed {
        logic               have;
        logic signed [31:0] best_value;
    } max_stat_t;

endpackage

// ===== rtl/ssd_store.sv =====
`timescale 1ns / 1ps

module ssd_store #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic                    aclk,
    input  logic                    wr_en,
    input  logic [IDX_W-1:0]        wr_addr,
    input  logic signed [31:0]      wr_data,
    input  logic [IDX_W-1:0]        rd_addr,
    output logic signed [31:0]      rd_data
);
    import ssd_pkg::*;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ssd_max_unit.sv =====
`timescale 1ns / 1ps

module ssd_max_unit #(
    parameter int IDX_W = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ssd_pkg::max_ctrl_t   ctrl,
    input  logic [IDX_W-1:0]     sample_index,
    output ssd_pkg::max_stat_t   stat,
    output logic [IDX_W-1:0]     best_index
);
    import ssd_pkg::*;

    logic               have_reg;
    logic signed [31:0] best_value_reg;
    logic [IDX_W-1:0]   best_index_reg;
    logic               take;

    // Strict compare keeps the first of equal candidates.
    assign take = ctrl.sample_en && (!have_reg || (ctrl.sample_value > best_value_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
        end else if (ctrl.clear) begin
            have_reg <= 1'b0;
        end else if (take) begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!ctrl.clear && take) begin
            best_value_reg <= ctrl.sample_value;
            best_index_reg <= sample_index;
        end
    end

    assign stat.have       = have_reg;
    assign stat.best_value = best_value_reg;
    assign best_index      = best_index_reg;

endmodule

// ===== rtl/sequence_sort_descending.sv =====
`timescale 1ns / 1ps
// Loading: one value per cycle, ready held high until the last-flagged transaction.
// Sorting: n selection passes for n stored values; each pass scans the store
// through its single registered read port with one shared compare unit.
// One result per pass, largest first; EMIT holds while m_valid waits for m_ready.
// Reset: aresetn sync, active low; clears FSM, count, flags, indices and handshake.
module sequence_sort_descending #(
    parameter int MAX_ITEMS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ssd_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ssd_pkg::out_item_t m_data
);
    import ssd_pkg::*;

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg;
    logic               overflow_reg;
    logic [MAX_ITEMS-1:0] used_reg;
    logic [IDX_W-1:0]   scan_idx_reg;
    logic [IDX_W-1:0]   emit_cnt_reg;
    logic               rd_valid_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    logic               in_fire;
    logic               has_room;
    logic               scan_done;
    logic               emit_fire;
    logic               emit_final;
    logic               start_scan;
    logic [IDX_W-1:0]   last_idx;
    logic signed [31:0] rd_data;
    logic [IDX_W-1:0]   best_index;
    max_ctrl_t          max_ctrl;
    max_stat_t          max_stat;

    assign in_fire    = s_valid && s_ready;
    assign has_room   = count_reg < CNT_W'(MAX_ITEMS);
    assign last_idx   = IDX_W'(count_reg - 1'b1);
    assign scan_done  = scan_idx_reg == last_idx;
    assign emit_final = emit_cnt_reg == last_idx;

    ssd_store #(
        .DEPTH (MAX_ITEMS),
        .IDX_W (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (in_fire && has_room),
        .wr_addr (IDX_W'(count_reg)),
        .wr_data (s_data.item_value),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data)
    );

    ssd_max_unit #(
        .IDX_W (IDX_W)
    ) u_max (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (max_ctrl),
        .sample_index (rd_idx_reg),
        .stat         (max_stat),
        .best_index   (best_index)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_fire && s_data.item_last) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = emit_final ? ST_LOAD : ST_SCAN;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_ready    = 1'b0;
        emit_fire  = 1'b0;
        start_scan = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready    = 1'b1;
                start_scan = in_fire && s_data.item_last;
            end
            ST_EMIT: begin
                emit_fire  = !m_valid_reg || m_ready;
                start_scan = emit_fire && !emit_final;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        max_ctrl.clear        = start_scan;
        max_ctrl.sample_en    = rd_valid_reg && !used_reg[rd_idx_reg];
        max_ctrl.sample_value = rd_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            used_reg     <= '0;
            scan_idx_reg <= '0;
            emit_cnt_reg <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= state_reg == ST_SCAN;
            if (in_fire) begin
                if (has_room) begin
                    count_reg <= count_reg + 1'b1;
                end else begin
                    overflow_reg <= 1'b1;
                end
            end
            if (start_scan) begin
                scan_idx_reg <= '0;
            end else if (state_reg == ST_SCAN && !scan_done) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
                if (emit_final) begin
                    // Burst complete: drop the run state
                    count_reg    <= '0;
                    overflow_reg <= 1'b0;
                    used_reg     <= '0;
                    emit_cnt_reg <= '0;
                end else begin
                    used_reg[best_index] <= 1'b1;
                    emit_cnt_reg         <= emit_cnt_reg + 1'b1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= scan_idx_reg;
        if (emit_fire) begin
            m_data_reg.sorted_value <= max_stat.best_value;
            m_data_reg.sorted_last  <= emit_final;
            m_data_reg.dropped      <= overflow_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_emit_has_candidate: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> max_stat.have)
        else $error("emit without a selected candidate");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count beyond capacity");

    a_scan_has_unused: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> ($countones(used_reg) < int'(count_reg)))
        else $error("scan started with every entry already emitted");

endmodule

// ===== tb/sequence_sort_descending_checker.sv =====
`timescale 1ns / 1ps

module sequence_sort_descending_checker #(
    parameter int MAX_ITEMS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  ssd_pkg::in_item_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  ssd_pkg::out_item_t m_data,
    output int                 fail_count,
    output int                 results_owed
);

    import ssd_pkg::*;

    logic signed [31:0] held_values[$];
    bit                 spill_seen;
    out_item_t          sorted_expected[$];
    int                 result_index;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("[%0t] result %0d: %s: got %0h, expected %0h",
                 $time, result_index, what, got, want);
    endtask

    // Store the value, or flag a spill once full; on the last transaction of a sequence,
    // queue the stored values largest first and start a new sequence.
    function automatic void take_value(in_item_t item);
        logic signed [31:0] ordered[$];
        logic signed [31:0] key;
        int                 pos;
        out_item_t          res;
        if (held_values.size() < MAX_ITEMS) begin
            held_values.push_back(item.item_value);
        end else begin
            spill_seen = 1'b1;
        end
        if (!item.item_last) begin
            return;
        end
        foreach (held_values[i]) begin
            key = held_values[i];
            pos = 0;
            while (pos < ordered.size() && ordered[pos] >= key) begin
                pos++;
            end
            ordered.insert(pos, key);
        end
        foreach (ordered[i]) begin
            res.sorted_value = ordered[i];
            res.sorted_last  = (i == ordered.size() - 1);
            res.dropped      = spill_seen;
            sorted_expected.push_back(res);
        end
        held_values.delete();
        spill_seen = 1'b0;
    endfunction

    task automatic compare_result(input out_item_t got);
        out_item_t want;
        if (sorted_expected.size() == 0) begin
            report_mismatch("unexpected transaction", got.sorted_value, '0);
        end else begin
            want = sorted_expected.pop_front();
            if (got.sorted_value !== want.sorted_value) begin
                report_mismatch("sorted_value", got.sorted_value, want.sorted_value);
            end
            if (got.sorted_last !== want.sorted_last) begin
                report_mismatch("sorted_last", got.sorted_last, want.sorted_last);
            end
            if (got.dropped !== want.dropped) begin
                report_mismatch("dropped", got.dropped, want.dropped);
            end
        end
        result_index++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            held_values.delete();
            sorted_expected.delete();
            spill_seen   = 1'b0;
            result_index = 0;
            fail_count   = 0;
            results_owed <= 0;
        end else begin
            if (m_valid && m_ready) begin
                compare_result(m_data);
            end
            if (s_valid && s_ready) begin
                take_value(s_data);
            end
            results_owed <= sorted_expected.size();
        end
    end

endmodule

// ===== tb/sequence_sort_descending_test.sv =====
`timescale 1ns / 1ps

module sequence_sort_descending_test;

    import ssd_pkg::*;

    localparam int MAX_ITEMS    = 64;
    localparam int TARGET_ITEMS = 420;

    typedef enum int {
        VALUES_WIDE,
        VALUES_NARROW,
        VALUES_EXTREME,
        VALUES_NEGATIVE
    } value_mix_t;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_SPARSE,
        READY_PERIODIC
    } ready_mode_t;

    localparam logic signed [31:0] EDGE_VALUES [6] = '{
        32'sh7fffffff, 32'sh80000000, 32'sh00000000,
        32'shffffffff, 32'sh00000001, 32'sh80000001
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    int          fail_count;
    int          results_owed;

    int          items_sent;
    int          burst_left;
    int          stall_cycle;
    ready_mode_t stall_mode;

    sequence_sort_descending #(
        .MAX_ITEMS(MAX_ITEMS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    sequence_sort_descending_checker #(
        .MAX_ITEMS(MAX_ITEMS)
    ) checker_inst (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Receiver: periodically switch at random between stall patterns.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready     <= 1'b0;
            stall_cycle <= 0;
            stall_mode  <= READY_ALWAYS;
        end else begin
            stall_cycle <= stall_cycle + 1;
            if (stall_cycle % 300 == 0) begin
                stall_mode <= ready_mode_t'($urandom_range(0, 3));
            end
            case (stall_mode)
                READY_ALWAYS: begin
                    m_ready <= 1'b1;
                end
                READY_RANDOM: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                READY_SPARSE: begin
                    m_ready <= ($urandom_range(0, 5) == 0);
                end
                default: begin
                    m_ready <= (stall_cycle % 8 < 3);
                end
            endcase
        end
    end

    function automatic logic signed [31:0] pick_value(input value_mix_t mix);
        case (mix)
            VALUES_WIDE:    return $urandom;
            VALUES_NARROW:  return int'($urandom_range(0, 16)) - 8;
            VALUES_EXTREME: return EDGE_VALUES[$urandom_range(0, 5)];
            default:        return {1'b1, 31'($urandom)};
        endcase
    endfunction

    // Hold valid until the transaction is taken; idle between random bursts.
    task automatic push_item(input logic signed [31:0] value, input logic is_last);
        in_item_t next_item;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        next_item.item_value = value;
        next_item.item_last  = is_last;
        s_valid <= 1'b1;
        s_data  <= next_item;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_sequence(input int len, input value_mix_t mix);
        for (int i = 0; i < len; i++) begin
            push_item(pick_value(mix), i == len - 1);
        end
    endtask

    initial begin
        int         seq_index;
        int         len;
        int         pick;
        value_mix_t mix;

        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        items_sent = 0;
        burst_left = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-value sequences at both extremes
        push_item(32'sh7fffffff, 1'b1);
        push_item(32'sh80000000, 1'b1);
        // mixed signs, duplicates, alternating bit patterns
        push_item(32'sh00000000, 1'b0);
        push_item(32'shffffffff, 1'b0);
        push_item(32'sh00000001, 1'b0);
        push_item(32'sh7fffffff, 1'b0);
        push_item(32'sh80000000, 1'b0);
        push_item(32'shffffffff, 1'b0);
        push_item(32'sh00000000, 1'b0);
        push_item(32'sh55555555, 1'b0);
        push_item(32'shaaaaaaaa, 1'b1);
        // already ascending, must come out reversed
        for (int v = -3; v <= 2; v++) begin
            push_item(v, v == 2);
        end
        // all equal
        for (int i = 0; i < 4; i++) begin
            push_item(32'sd5, i == 3);
        end

        // Random sequences: first fill the store exactly, then overflow it
        // by one and by several; afterwards mostly short sequences.
        seq_index = 0;
        while (items_sent < TARGET_ITEMS) begin
            case (seq_index)
                0: begin
                    len = MAX_ITEMS;
                end
                1: begin
                    len = MAX_ITEMS + 1;
                end
                2: begin
                    len = MAX_ITEMS + 6;
                end
                default: begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60) begin
                        len = $urandom_range(1, 8);
                    end else if (pick < 85) begin
                        len = $urandom_range(9, 24);
                    end else if (pick < 95) begin
                        len = $urandom_range(25, MAX_ITEMS - 1);
                    end else begin
                        len = $urandom_range(MAX_ITEMS, MAX_ITEMS + 8);
                    end
                end
            endcase
            mix = value_mix_t'($urandom_range(0, 3));
            send_sequence(len, mix);
            seq_index++;
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && results_owed == 0) begin
            $display("** sequence_sort_descending: PASSED **");
        end else begin
            $display("** sequence_sort_descending: FAILED **");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("** sequence_sort_descending: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ssd_pkg.sv
rtl/ssd_store.sv
rtl/ssd_max_unit.sv
rtl/sequence_sort_descending.sv
tb/sequence_sort_descending_checker.sv
tb/sequence_sort_descending_test.sv
